// ===== src/tch_pkg.sv =====
`default_nettype none
package tch_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int TIDX_W      = $clog2(TABLE_DEPTH);
  localparam int WORD_W      = 64;
  localparam int FOLD_W      = WORD_W / 2;
  localparam int ROT_W       = $clog2(WORD_W);
  localparam int ROUNDS      = WORD_W / TIDX_W;
  localparam int ROUND_W     = $clog2(ROUNDS);
  localparam int KIND_W      = 2;

  localparam logic [KIND_W-1:0] KIND_LOAD_X = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_Y = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [TIDX_W-1:0] tidx_t;

  // rotate left; an amount of zero leaves the word as it is
  function automatic word_t rotl(input word_t v, input logic [ROT_W-1:0] amt);
    logic [2*WORD_W-1:0] dbl;
    dbl = {v, v} << amt;
    return dbl[2*WORD_W-1:WORD_W];
  endfunction

endpackage
`default_nettype wire

// ===== src/tch_in_if.sv =====
`default_nettype none
interface tch_in_if;
  import tch_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [TIDX_W-1:0]   table_index;
  logic [WORD_W-1:0]   table_word;
  logic [WORD_W-1:0]   coord_x;
  logic [WORD_W-1:0]   coord_y;

  modport source (output valid, kind, table_index, table_word, coord_x, coord_y,
                  input ready);
  modport sink   (input valid, kind, table_index, table_word, coord_x, coord_y,
                  output ready);
endinterface
`default_nettype wire

// ===== src/tch_out_if.sv =====
`default_nettype none
interface tch_out_if;
  import tch_pkg::*;

  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   hash_value;
  logic [FOLD_W-1:0]   folded_value;

  modport source (output valid, hash_value, folded_value, input ready);
  modport sink   (input valid, hash_value, folded_value, output ready);
endinterface
`default_nettype wire

// ===== src/tch_ram.sv =====
`default_nettype none
module tch_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/table_coordinate_hash.sv =====
`default_nettype none
// channel  dir  payload                                            beat
// in_chan  in   kind, table_index, table_word, coord_x, coord_y    one item
// out_chan out  hash_value, folded_value                           one result
//
// A load beat writes one table word.
// A query runs its rounds as S_MIX then S_ROT (byte read, then the dependent
// rotate-amount read through the x and y table RAMs), plus entry and exit.
// in_chan.ready is high whenever no query is running; one result register
// decouples the output, and a query holds in its last step while it is full.
// rst_n (synchronous) clears control only; tables are undefined until loaded.
module table_coordinate_hash (
  input wire logic clk,
  input wire logic rst_n,
  tch_in_if.sink   in_chan,
  tch_out_if.source out_chan
);
  import tch_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MIX  = 4'b0010,
    S_ROT  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [ROUND_W-1:0]       round_r, round_nxt;
  word_t                    cx_r, cx_nxt, cy_r, cy_nxt;
  logic [WORD_W-TIDX_W-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  word_t                    ax_r, ax_nxt, ay_r, ay_nxt;
  logic                     out_valid_r, out_valid_nxt;
  word_t                    hash_r, hash_nxt;

  logic  in_acc;
  word_t x_mix, y_mix, h;
  logic  x_we, y_we;
  tidx_t x_raddr, y_raddr;
  word_t x_rdata, y_rdata;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign x_we = in_acc && (in_chan.kind == KIND_LOAD_X);
  assign y_we = in_acc && (in_chan.kind == KIND_LOAD_Y);

  assign x_mix = (ax_r + cx_r) ^ x_rdata;
  assign y_mix = (ay_r + cy_r) ^ y_rdata;
  assign h     = ax_r ^ ay_r;

  always_comb begin
    case (state_r)
      S_IDLE: begin
        x_raddr = in_chan.coord_x[TIDX_W-1:0];
        y_raddr = in_chan.coord_y[TIDX_W-1:0];
      end
      S_MIX: begin
        x_raddr = y_mix[TIDX_W-1:0];
        y_raddr = x_mix[TIDX_W-1:0];
      end
      S_ROT: begin
        x_raddr = sx_r[TIDX_W-1:0];
        y_raddr = sy_r[TIDX_W-1:0];
      end
      default: begin
        x_raddr = '0;
        y_raddr = '0;
      end
    endcase
  end

  tch_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH)) u_x_ram (
    .clk   (clk),
    .we    (x_we),
    .waddr (in_chan.table_index),
    .wdata (in_chan.table_word),
    .raddr (x_raddr),
    .rdata (x_rdata)
  );

  tch_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH)) u_y_ram (
    .clk   (clk),
    .we    (y_we),
    .waddr (in_chan.table_index),
    .wdata (in_chan.table_word),
    .raddr (y_raddr),
    .rdata (y_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    round_nxt     = round_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    hash_nxt      = hash_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_chan.kind == KIND_QUERY)) begin
          cx_nxt    = in_chan.coord_x;
          cy_nxt    = in_chan.coord_y;
          sx_nxt    = in_chan.coord_x[WORD_W-1:TIDX_W];
          sy_nxt    = in_chan.coord_y[WORD_W-1:TIDX_W];
          ax_nxt    = '0;
          ay_nxt    = '0;
          round_nxt = '0;
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        ax_nxt    = x_mix;
        ay_nxt    = y_mix;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        ax_nxt = ax_r ^ rotl(cy_r, y_rdata[ROT_W-1:0]);
        ay_nxt = ay_r ^ rotl(cx_r, x_rdata[ROT_W-1:0]);
        sx_nxt = sx_r >> TIDX_W;
        sy_nxt = sy_r >> TIDX_W;
        if (round_r == ROUND_W'(ROUNDS - 1)) begin
          state_nxt = S_FIN;
        end else begin
          round_nxt = round_r + 1'b1;
          state_nxt = S_MIX;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          hash_nxt      = h;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      round_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      round_r     <= round_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    sx_r   <= sx_nxt;
    sy_r   <= sy_nxt;
    ax_r   <= ax_nxt;
    ay_r   <= ay_nxt;
    hash_r <= hash_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.hash_value   = hash_r;
  assign out_chan.folded_value = hash_r[WORD_W-1:FOLD_W] ^ hash_r[FOLD_W-1:0];

endmodule
`default_nettype wire
